@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file dtf_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define DTF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define DTF_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/dtf_pkg.sv @@
// Types, codes and defaults for the deduplicating task FIFO.
// No dependencies.
`default_nettype none

package dtf_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam logic       OP_ENQ     = 1'b0;
    localparam logic       OP_DEQ     = 1'b1;
    localparam logic [2:0] KIND_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic               op;
        logic [2:0]         task_kind;
        logic signed [31:0] task_ident;
        logic [31:0]        note_handle;
        logic               note_missing;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  out_kind;
        logic [30:0] out_ident;
        logic [31:0] out_handle;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] ident;
        logic [31:0] handle;
    } t_entry;

    typedef struct packed {
        logic    cap;
        logic    rd_start;
        logic    rd_next;
        logic    push;
        logic    pop;
        logic    set_res;
        logic    res_data;
        t_status res_status;
        logic    load_out;
    } t_dtf_cmd;

    typedef struct packed {
        logic is_deq;
        logic invalid;
        logic empty;
        logic full;
        logic match;
        logic scan_done;
        logic out_free;
    } t_dtf_sts;

endpackage

`default_nettype wire

@@ sv/dedup_task_fifo_top.sv @@
// Deduplicating task FIFO, top level; uses dtf_pkg, dtf_ctrl, dtf_datapath.
// Stored enqueue: the duplicate scan reads one ring entry per cycle and a match ends it;
//   a full queue is scanned in full before the enqueue is refused as full.
// One item at a time: the next transfer can be taken in the cycle after the result is loaded.
// Synchronous active-low reset empties the queue; entry memory is not cleared.
`default_nettype none

module dedup_task_fifo_top
    import dtf_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_dtf_cmd cmd;
    t_dtf_sts sts;

    dtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    dtf_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ sv/dtf_datapath.sv @@
// Datapath: request register, entry ring memory, pointers, scan counter, result registers.
// Depends on dtf_pkg.
`default_nettype none

module dtf_datapath
    import dtf_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_ready,
    input  wire t_dtf_cmd  i_cmd,
    output t_dtf_sts       o_sts,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    t_entry         r_mem [CAPACITY];
    t_entry         r_rd_data;
    t_in_item       r_req;
    logic [AW-1:0]  r_head, r_tail, r_ptr;
    logic [CW-1:0]  r_count, r_scan;
    t_out_item      r_res, r_out;
    logic           r_out_valid;

    logic [AW-1:0]  rd_addr;
    logic           rd_en;
    t_entry         wr_entry;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign rd_en    = i_cmd.rd_start | i_cmd.rd_next;
    assign rd_addr  = i_cmd.rd_next ? r_ptr : r_head;
    assign wr_entry = '{kind: r_req.task_kind, ident: r_req.task_ident[30:0],
                        handle: r_req.note_handle};

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= wr_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= i_in_item;
        end
        if (i_cmd.rd_start) begin
            r_ptr  <= ring_next(r_head);
            r_scan <= CW'(1);
        end else if (i_cmd.rd_next) begin
            r_ptr  <= ring_next(r_ptr);
            r_scan <= r_scan + CW'(1);
        end
        if (i_cmd.set_res) begin
            r_res.status     <= i_cmd.res_status;
            r_res.out_kind   <= i_cmd.res_data ? r_rd_data.kind   : 3'd0;
            r_res.out_ident  <= i_cmd.res_data ? r_rd_data.ident  : 31'd0;
            r_res.out_handle <= i_cmd.res_data ? r_rd_data.handle : 32'd0;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_tail  <= ring_next(r_tail);
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_head  <= ring_next(r_head);
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.is_deq    = (r_req.op == OP_DEQ);
        o_sts.invalid   = r_req.task_ident[31] | r_req.note_missing
                        | (r_req.task_kind > KIND_LIMIT);
        o_sts.empty     = (r_count == '0);
        o_sts.full      = (r_count == CW'(CAPACITY));
        o_sts.match     = (r_rd_data.kind == r_req.task_kind)
                        && (r_rd_data.ident == r_req.task_ident[30:0]);
        o_sts.scan_done = (r_scan == r_count);
        o_sts.out_free  = !r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ sv/dtf_ctrl.sv @@
// Controller: sequences capture, duplicate scan, write, read and result hand-off.
// Depends on dtf_pkg.
`default_nettype none

module dtf_ctrl
    import dtf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dtf_sts i_sts,
    output logic          o_in_ready,
    output t_dtf_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WRITE,
        S_POP,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_deq) begin
                    if (i_sts.empty) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_EMPTY;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_POP;
                    end
                end else if (i_sts.invalid) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_INVALID;
                    n_state          = S_DONE;
                end else if (i_sts.empty) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_DUPLICATE;
                    n_state          = S_DONE;
                end else if (i_sts.scan_done) begin
                    if (i_sts.full) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.push       = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_POP: begin
                o_cmd.pop        = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_data   = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/dtf_checker.sv @@
// Port-level checks for dedup_task_fifo_top, bound to the top level.
// Depends on dtf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dtf_checker
    import dtf_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    `DTF_ASSERT(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `DTF_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "result dropped or changed while stalled")
    `DTF_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "second transfer taken while busy")
    `DTF_ASSERT_RST(a_zero_payload, i_clk, i_rst_n, o_out_valid && o_out_item.status != ST_OK |-> o_out_item.out_kind == 3'd0 && o_out_item.out_ident == 31'd0 && o_out_item.out_handle == 32'd0, "refused result carries payload")

endmodule

bind dedup_task_fifo_top dtf_checker u_dtf_checker (.*);

`default_nettype wire
